[hw/rtl/lzc_pkg.sv]
// ----------------------------------------------------------------------------
// lzc_pkg
// Shared types and constants for the greedy LZ77 compressor.
// ----------------------------------------------------------------------------
package lzc_pkg;

    // cells per group, and bits of an index within a group
    localparam int GRP_SIZE = 32;
    localparam int GRP_W    = 5;

    // width of the run and fill counts seen by the cells (covers the
    // largest window and the largest run cap)
    localparam int CNT_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_SCAN,
        ST_OUT
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             clear;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] run_len;
        logic [CNT_W-1:0] fill_cnt;
    } cell_ctrl_t;

endpackage

[hw/rtl/lz77_greedy_compressor.sv]
// ----------------------------------------------------------------------------
// lz77_greedy_compressor
// Greedy longest-match LZ77 tokenizer over a row of history cells.
//
//  channel | dir | tdata (low bit up)                          | side
//  s_      | in  | data_byte                                   | tlast = last_byte
//  m_      | out | distance, length, literal, has_literal, pad | tlast = last_token
//
// Each byte passes through the compare in the cells, the per-group encoding,
// then a scan over the group flags that looks at 32 groups per cycle from the
// oldest end, over up to NB = ceil(WINDOW / 1024) blocks, until a hit.
// Reset clears the match flags and counters; history bytes are not cleared.
// A token held in the output register stalls the controller, and so the input, only when the next byte emits.
// ----------------------------------------------------------------------------
module lz77_greedy_compressor import lzc_pkg::*; #(
    parameter int WINDOW    = 1024,
    parameter int MAX_MATCH = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [10:0] distance, [18:11] length,
                                   // [26:19] literal, [27] has_literal, zero pad
    output logic        m_tlast
);

    localparam int NG    = (WINDOW + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NB    = (NG + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NGP   = NB * GRP_SIZE;
    localparam int NCP   = NGP * GRP_SIZE;
    localparam int BLK_W = (NB > 1) ? $clog2(NB) : 1;
    localparam int DW    = $clog2(WINDOW + 1);
    localparam int RUN_W = $clog2(MAX_MATCH + 1);

    state_t state_reg, state_next;

    logic [RUN_W-1:0] run_reg, run_next;
    logic [DW-1:0]    filled_reg, filled_next;
    logic [DW-1:0]    best_reg, best_next;
    logic [DW-1:0]    top_reg, top_next;
    logic             any_reg, any_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [BLK_W-1:0] blk_reg, blk_next;

    logic [NGP-1:0]   grp_any_reg;
    logic [GRP_W-1:0] grp_idx_reg [NGP];
    logic [NGP-1:0]   grp_any_w;
    logic [GRP_W-1:0] grp_idx_w [NGP];
    logic [GRP_W-1:0] top_idx [GRP_SIZE];

    logic             m_valid_reg, m_valid_next;
    logic [10:0]      m_dist_reg;
    logic [7:0]       m_len_reg;
    logic [7:0]       m_lit_reg;
    logic             m_has_lit_reg;
    logic             m_last_reg;

    logic             accept;
    logic             scan_done;
    logic             fire_out;
    logic             extend;
    logic             emit;
    logic             bany;
    logic [GRP_W-1:0] bidx;
    logic [15:0]      len_w;
    logic [15:0]      dist_w;

    cell_ctrl_t       ctrl;
    logic [7:0]       hist_w [WINDOW+1];
    logic [NCP-1:0]   alive_vec;

    // ---------------------------------------------------------------- cells
    assign accept = s_tvalid && s_tready;

    always_comb begin
        ctrl.cmp_en    = accept;
        ctrl.clear     = fire_out && emit;
        ctrl.data_byte = s_tdata[7:0];
        ctrl.run_len   = CNT_W'(run_reg);
        ctrl.fill_cnt  = CNT_W'(filled_reg);
    end

    assign hist_w[0] = s_tdata[7:0];

    for (genvar k = 0; k < NCP; k++) begin : g_cell
        if (k < WINDOW) begin : g_real
            lzc_cell #(.D(k + 1)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .hist_in   (hist_w[k]),
                .hist_out  (hist_w[k+1]),
                .alive_out (alive_vec[k])
            );
        end else begin : g_pad
            assign alive_vec[k] = 1'b0;
        end
    end

    // ---------------------------------------------------------- group encode
    for (genvar g = 0; g < NGP; g++) begin : g_grp
        lzc_prio u_prio (
            .bits  (alive_vec[g*GRP_SIZE +: GRP_SIZE]),
            .found (grp_any_w[g]),
            .idx   (grp_idx_w[g])
        );
    end

    for (genvar j = 0; j < GRP_SIZE; j++) begin : g_top
        assign top_idx[j] = grp_idx_reg[NGP-GRP_SIZE+j];
    end

    lzc_prio u_blk_prio (
        .bits  (grp_any_reg[NGP-1 -: GRP_SIZE]),
        .found (bany),
        .idx   (bidx)
    );

    // oldest groups sit at the top; shift younger blocks up until a hit or the last block
    always_ff @(posedge aclk) begin
        if (state_reg == ST_GROUP) begin
            grp_any_reg <= grp_any_w;
            for (int i = 0; i < NGP; i++) begin
                grp_idx_reg[i] <= grp_idx_w[i];
            end
        end else if (state_reg == ST_SCAN && !scan_done) begin
            grp_any_reg <= grp_any_reg << GRP_SIZE;
            for (int i = GRP_SIZE; i < NGP; i++) begin
                grp_idx_reg[i] <= grp_idx_reg[i-GRP_SIZE];
            end
        end
    end

    assign scan_done = bany || (blk_reg == '0);

    // ------------------------------------------------------------ control
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        fire_out   = 1'b0;
        blk_next   = blk_reg;
        any_next   = any_reg;
        top_next   = top_reg;

        extend = any_reg && (run_reg < RUN_W'(MAX_MATCH));
        emit   = !extend || last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_GROUP;
                end
            end
            ST_GROUP: begin
                blk_next   = BLK_W'(NB - 1);
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) begin
                    any_next   = bany;
                    top_next   = DW'({blk_reg, bidx, top_idx[bidx]}) + DW'(1);
                    state_next = ST_OUT;
                end else begin
                    blk_next = blk_reg - BLK_W'(1);
                end
            end
            ST_OUT: begin
                if (!emit || !m_valid_reg || m_tready) begin
                    fire_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        run_next     = run_reg;
        best_next    = best_reg;
        filled_next  = filled_reg;
        m_valid_next = m_valid_reg && !m_tready;
        len_w        = 16'(run_reg) + 16'(extend);
        dist_w       = extend ? 16'(top_reg) : 16'(best_reg);
        if (fire_out) begin
            if (emit) begin
                run_next     = '0;
                best_next    = '0;
                m_valid_next = 1'b1;
            end else begin
                run_next  = run_reg + RUN_W'(1);
                best_next = top_reg;
            end
            if (last_reg) begin
                filled_next = '0;
            end else if (filled_reg < DW'(WINDOW)) begin
                filled_next = filled_reg + DW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_reg     <= '0;
            filled_reg  <= '0;
            best_reg    <= '0;
            any_reg     <= 1'b0;
            blk_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_reg     <= run_next;
            filled_reg  <= filled_next;
            best_reg    <= best_next;
            any_reg     <= any_next;
            blk_reg     <= blk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (accept) begin
            byte_reg <= s_tdata[7:0];
            last_reg <= s_tlast;
        end
        if (fire_out && emit) begin
            m_dist_reg    <= dist_w[10:0];
            m_len_reg     <= len_w[7:0];
            m_lit_reg     <= extend ? 8'h00 : byte_reg;
            m_has_lit_reg <= !extend;
            m_last_reg    <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_has_lit_reg, m_lit_reg, m_len_reg, m_dist_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_accept_to_group: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_GROUP))
        else $error("accepted byte did not start group encode");

    a_run_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= RUN_W'(MAX_MATCH))
        else $error("run length beyond cap");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= DW'(WINDOW))
        else $error("fill count beyond window");

    a_source_before_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && any_reg) |-> (CNT_W'(top_reg) > CNT_W'(run_reg)))
        else $error("match source overlaps token");

    a_token_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("token issued outside output step");
`endif

endmodule

[hw/rtl/lzc_cell.sv]
// ----------------------------------------------------------------------------
// lzc_cell
// One history position: holds a byte and its still-matching flag, and hands
// the byte to the next cell on every compare.
// ----------------------------------------------------------------------------
module lzc_cell import lzc_pkg::*; #(
    parameter int D = 1
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] hist_in,
    output logic [7:0] hist_out,
    output logic       alive_out
);

    localparam logic [CNT_W-1:0] DIST = CNT_W'(D);

    logic [7:0] hist_reg;
    logic       alive_reg;
    logic       alive_next;
    logic       was_alive;
    logic       now_alive;

    always_comb begin
        // at the start of a token every filled position is a candidate
        was_alive  = (ctrl.run_len == '0) ? (DIST <= ctrl.fill_cnt) : alive_reg;
        // the source must end before the token start
        now_alive  = was_alive && (ctrl.run_len < DIST) && (hist_reg == ctrl.data_byte);
        alive_next = alive_reg;
        if (ctrl.clear) begin
            alive_next = 1'b0;
        end else if (ctrl.cmp_en) begin
            alive_next = now_alive;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= 1'b0;
        end else begin
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            hist_reg <= hist_in;
        end
    end

    assign hist_out  = hist_reg;
    assign alive_out = alive_reg;

endmodule

[hw/rtl/lzc_prio.sv]
// ----------------------------------------------------------------------------
// lzc_prio
// Priority encoder over one group: flags any set bit and the highest index.
// ----------------------------------------------------------------------------
module lzc_prio import lzc_pkg::*; (
    input  logic [GRP_SIZE-1:0] bits,
    output logic                found,
    output logic [GRP_W-1:0]    idx
);

    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < GRP_SIZE; i++) begin
            if (bits[i]) begin
                found = 1'b1;
                idx   = GRP_W'(i);
            end
        end
    end

endmodule
